### rtl/bpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared sizes, codes and types of the bounded priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int CAPACITY      = 8;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
    localparam int ACTION_BITS   = 2;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/bpq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_req_if / bpq_rsp_if
// Valid/ready channels for queue requests and their results.
// ----------------------------------------------------------------------------
interface bpq_req_if import bpq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [ACTION_BITS-1:0]       action;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic [PRIORITY_BITS-1:0]     entry_priority;

    modport source (output valid, action, entry_value, entry_priority, input ready);
    modport sink   (input valid, action, entry_value, entry_priority, output ready);
endinterface

interface bpq_rsp_if import bpq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [STATUS_BITS-1:0]       status;
    logic signed [VALUE_BITS-1:0] head_value;
    logic [PRIORITY_BITS-1:0]     head_priority;
    logic [COUNT_BITS-1:0]        occupancy;

    modport source (output valid, status, head_value, head_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, head_value, head_priority, occupancy,
                    output ready);
endinterface
`default_nettype wire

### rtl/bpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted chain: holds an entry, shifts toward the tail on
// enqueue and toward the head on dequeue.
// ----------------------------------------------------------------------------
module bpq_cell import bpq_pkg::*; (
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       left_ge,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output logic            ge,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // new entry goes in front of this slot's entry, or slot is past the tail
    assign ge = !occupied || (entry_reg.prio >= ctrl.new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && ge)
        begin
            entry_next = left_ge ? left_entry : ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

### rtl/bounded_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Sorted priority queue built as a chain of shifting slot cells.
// ----------------------------------------------------------------------------
//  channel  role  carries
//  req      sink  action, entry_value, entry_priority
//  rsp      src   status, head_value, head_priority, occupancy
//
//  One item per cycle while req.ready is high: the slot chain compares and
//  shifts on acceptance, and the result lands in an output register in the
//  cycle after acceptance. req.ready is high while the output register is
//  empty or being drained. Reset clears the fill count and the output valid;
//  slot contents are not cleared, only slots below the fill count are read.
// ----------------------------------------------------------------------------
module bounded_priority_queue import bpq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bpq_req_if.sink   req,
    bpq_rsp_if.source rsp
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  rsp_valid_reg;
    status_t               status_reg;
    status_t               status_next;
    entry_t                head_reg;
    entry_t                head_next;
    logic [COUNT_BITS-1:0] occ_reg;

    cell_ctrl_t            ctrl;
    logic                  fire;
    logic                  full;
    logic                  empty;

    entry_t                cell_entry [CAPACITY];
    logic                  cell_ge    [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctrl.enq            = 1'b0;
        ctrl.deq            = 1'b0;
        ctrl.new_entry.value = req.entry_value;
        ctrl.new_entry.prio  = req.entry_priority;
        count_next          = count_reg;
        status_next         = ST_DONE;
        head_next           = '0;
        case (action_t'(req.action))
            ACT_ENQUEUE:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.enq   = fire;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_DEQUEUE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.deq   = fire;
                    head_next  = cell_entry[0];
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next = cell_entry[0];
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic   occupied;
            logic   left_ge;
            entry_t left_entry;
            entry_t right_entry;

            assign occupied = (COUNT_BITS'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_ge    = 1'b0;
                assign left_entry = ctrl.new_entry;
            end
            else
            begin : g_body
                assign left_ge    = cell_ge[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_link
                assign right_entry = cell_entry[i+1];
            end

            bpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied),
                .left_ge     (left_ge),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .ge          (cell_ge[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            head_reg   <= head_next;
            occ_reg    <= count_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.head_value    = head_reg.value;
    assign rsp.head_priority = head_reg.prio;
    assign rsp.occupancy     = occ_reg;

endmodule
`default_nettype wire

### rtl/bpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the bounded priority queue.
// ----------------------------------------------------------------------------
module bpq_checker import bpq_pkg::*; (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [STATUS_BITS-1:0]       rsp_status,
    input wire logic signed [VALUE_BITS-1:0] rsp_head_value,
    input wire logic [PRIORITY_BITS-1:0]     rsp_head_priority,
    input wire logic [COUNT_BITS-1:0]        rsp_occupancy
);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_occupancy <= COUNT_BITS'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == COUNT_BITS'(CAPACITY))
        else $error("full rejection with free slots");

    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY
            |-> rsp_occupancy == '0 && rsp_head_value == '0 && rsp_head_priority == '0)
        else $error("empty rejection with data");

    a_fire_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted item produced no result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_occupancy))
        else $error("stalled result changed");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_head_value    (rsp.head_value),
    .rsp_head_priority (rsp.head_priority),
    .rsp_occupancy     (rsp.occupancy)
);
`default_nettype wire

### bench/bounded_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_tb
// Drives enqueue, dequeue, peek and unused requests into the queue and checks
// every result against a sorted-slot mirror of the queue kept in the bench.
// ----------------------------------------------------------------------------
module bounded_priority_queue_tb;
    import bpq_pkg::*;

    localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1527;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 8;

    typedef struct {
        logic [ACTION_BITS-1:0]       action;
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
        int unsigned                  gap;
        bit                           drain;
    } request_t;

    typedef struct {
        logic [STATUS_BITS-1:0]       status;
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
        logic [COUNT_BITS-1:0]        occupancy;
    } result_t;

    logic clk;
    logic rst_n;

    bpq_req_if req ();
    bpq_rsp_if rsp ();

    bounded_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    request_t request_backlog[$];
    result_t  owed_results[$];

    logic signed [VALUE_BITS-1:0] mirror_value [CAPACITY];
    logic [PRIORITY_BITS-1:0]     mirror_prio  [CAPACITY];
    int                           mirror_count;

    int          error_count;
    int          cycle_count;
    bit          offer_next;
    bit          hold_loaded;
    int unsigned hold_left;
    bit          ready_next;
    bit          stall_phase;
    int unsigned stall_left;
    result_t     due;

    // Sorted insert: new entry goes ahead of the first slot with priority >= its own.
    function automatic result_t serve_request(input request_t rq);
        result_t r;
        int      pos;
        int      k;
        r.status = ST_DONE;
        r.value  = '0;
        r.prio   = '0;
        pos      = 0;
        case (rq.action)
            ACT_ENQUEUE:
            begin
                if (mirror_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    while (pos < mirror_count && mirror_prio[pos] < rq.prio)
                        pos++;
                    for (k = mirror_count; k > pos; k--)
                    begin
                        mirror_value[k] = mirror_value[k-1];
                        mirror_prio[k]  = mirror_prio[k-1];
                    end
                    mirror_value[pos] = rq.value;
                    mirror_prio[pos]  = rq.prio;
                    mirror_count++;
                end
            end
            ACT_DEQUEUE, ACT_PEEK:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.value = mirror_value[0];
                    r.prio  = mirror_prio[0];
                    if (rq.action == ACT_DEQUEUE)
                    begin
                        for (k = 1; k < mirror_count; k++)
                        begin
                            mirror_value[k-1] = mirror_value[k];
                            mirror_prio[k-1]  = mirror_prio[k];
                        end
                        mirror_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = COUNT_BITS'(mirror_count);
        return r;
    endfunction

    task automatic add_request(input logic [ACTION_BITS-1:0] action,
                               input logic signed [VALUE_BITS-1:0] value,
                               input logic [PRIORITY_BITS-1:0] prio,
                               input int unsigned gap, input bit drain);
        request_t rq;
        rq.action = action;
        rq.value  = value;
        rq.prio   = prio;
        rq.gap    = gap;
        rq.drain  = drain;
        request_backlog.push_back(rq);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.action         = ACT_ENQUEUE;
        req.entry_value    = '0;
        req.entry_priority = '0;
        rsp.ready          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            offer_next = req.valid;
            if (req.valid && req.ready)
            begin
                owed_results.push_back(serve_request(request_backlog.pop_front()));
                offer_next = 1'b0;
            end
            if (!offer_next && request_backlog.size() > 0)
            begin
                if (!hold_loaded)
                begin
                    hold_left   = request_backlog[0].gap;
                    hold_loaded = 1'b1;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                end
                else if (!request_backlog[0].drain || owed_results.size() == 0)
                begin
                    offer_next          = 1'b1;
                    hold_loaded         = 1'b0;
                    req.action         <= request_backlog[0].action;
                    req.entry_value    <= request_backlog[0].value;
                    req.entry_priority <= request_backlog[0].prio;
                end
            end
            req.valid <= offer_next;
        end
    end

    // result monitor and ready stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    error_count++;
                end
                else
                begin
                    due = owed_results.pop_front();
                    if (rsp.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.head_value !== due.value)
                    begin
                        $error("head_value: expected %0d, got %0d", due.value, rsp.head_value);
                        error_count++;
                    end
                    if (rsp.head_priority !== due.prio)
                    begin
                        $error("head_priority: expected %0d, got %0d",
                               due.prio, rsp.head_priority);
                        error_count++;
                    end
                    if (rsp.occupancy !== due.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               due.occupancy, rsp.occupancy);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                stall_phase = !stall_phase;
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (stall_phase && request_backlog.size() >= CALM_TAIL &&
                     $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
            end
            rsp.ready <= ready_next;
        end
    end

    initial
    begin
        int          sel;
        int unsigned enq_pct;
        int unsigned gap_pct;
        int unsigned prio_mode;
        bit          tail;
        logic [ACTION_BITS-1:0]       act;
        logic signed [VALUE_BITS-1:0] val;
        logic [PRIORITY_BITS-1:0]     pri;

        error_count = 0;
        cycle_count = 0;
        mirror_count = 0;
        hold_loaded = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        stall_phase = 1'b1;
        enq_pct   = 50;
        gap_pct   = 20;
        prio_mode = 0;

        // empty queue: every read is rejected, unused code is a no-op
        add_request(ACT_PEEK, 32'sd0, 8'd0, 0, 1'b0);
        add_request(ACT_DEQUEUE, 32'sd0, 8'd0, 0, 1'b0);
        add_request(ACT_NONE, 32'sd0, 8'd0, 0, 1'b0);
        // fill with extremes and ties
        add_request(ACT_ENQUEUE, 32'sh8000_0000, 8'd255, 0, 1'b0);
        add_request(ACT_ENQUEUE, 32'sh7fff_ffff, 8'd0, 0, 1'b0);
        add_request(ACT_ENQUEUE, 32'sd0, 8'd0, 0, 1'b0);
        add_request(ACT_ENQUEUE, -32'sd1, 8'd255, 0, 1'b0);
        add_request(ACT_ENQUEUE, 32'sd123, 8'd128, 0, 1'b0);
        add_request(ACT_ENQUEUE, -32'sd5, 8'd1, 0, 1'b0);
        add_request(ACT_ENQUEUE, 32'sh5555_aaaa, 8'd254, 0, 1'b0);
        add_request(ACT_ENQUEUE, 32'shaaaa_5555, 8'd0, 0, 1'b0);
        // full queue
        add_request(ACT_ENQUEUE, 32'sd77, 8'd3, 0, 1'b0);
        add_request(ACT_NONE, -32'sd1, 8'd255, 0, 1'b0);
        add_request(ACT_PEEK, 32'sd0, 8'd0, 0, 1'b0);
        repeat (CAPACITY + 1)
            add_request(ACT_DEQUEUE, -32'sd1, 8'd255, 0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 24 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 20;
                    1: enq_pct = 50;
                    2: enq_pct = 75;
                    default: enq_pct = 95;
                endcase
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 20;
                prio_mode = $urandom_range(0, 2);
            end
            tail = (i >= RANDOM_ITEMS - CALM_TAIL);
            sel  = $urandom_range(0, 99);
            if (sel < 3)
                act = ACT_NONE;
            else if (sel < enq_pct)
                act = ACT_ENQUEUE;
            else if ($urandom_range(0, 3) == 0)
                act = ACT_PEEK;
            else
                act = ACT_DEQUEUE;
            case ($urandom_range(0, 15))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = -32'sd1;
                default: val = $urandom;
            endcase
            case (prio_mode)
                0: pri = PRIORITY_BITS'($urandom_range(0, 255));
                1: pri = PRIORITY_BITS'($urandom_range(0, 3));
                default: pri = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            endcase
            add_request(act, val, pri,
                        (!tail && $urandom_range(0, 99) < gap_pct) ?
                            $urandom_range(1, 12) : 0,
                        (i % 300 == 0));
        end

        while (request_backlog.size() > 0 || owed_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (error_count == 0 && owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/bpq_pkg.sv
rtl/bpq_if.sv
rtl/bpq_cell.sv
rtl/bounded_priority_queue.sv
rtl/bpq_checker.sv
bench/bounded_priority_queue_tb.sv
